// File: sv/utf8_script_filter_validator_core_defines.svh
// Assertion macros shared by the validator RTL.
// The clocked form needs clk_i and rst_ni in the module that uses it.
`ifndef UTF8_SCRIPT_FILTER_VALIDATOR_CORE_DEFINES_SVH
`define UTF8_SCRIPT_FILTER_VALIDATOR_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define USV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("usv assertion failed");
`define USV_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("usv assertion failed during reset");
`else
`define USV_ASSERT(lbl, prop)
`define USV_ASSERT_NR(lbl, prop)
`endif

`endif

// File: sv/usv_pkg.sv
package usv_pkg;

  localparam int unsigned CodeW  = 21;
  localparam int unsigned AccW   = 15;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Byte ranges of strict UTF-8: ASCII, continuation and lead bytes.
  localparam logic [7:0] AsciiMax  = 8'h7F;
  localparam logic [7:0] ContMin   = 8'h80;
  localparam logic [7:0] ContMax   = 8'hBF;
  localparam logic [7:0] Lead2Min  = 8'hC2;
  localparam logic [7:0] Lead2Max  = 8'hDF;
  localparam logic [7:0] Lead3Min  = 8'hE0;
  localparam logic [7:0] Lead3Max  = 8'hEF;
  localparam logic [7:0] Lead4Min  = 8'hF0;
  localparam logic [7:0] Lead4Max  = 8'hF4;

  typedef enum logic [1:0] {
    ST_BOUNDARY = 2'd0,
    ST_INSIDE   = 2'd1,
    ST_REJECTED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    K_ASCII,
    K_LEAD2,
    K_LEAD3,
    K_LEAD4,
    K_CONT,
    K_BAD
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_fresh;
  } in_t;

  typedef struct packed {
    status_e          status;
    logic             code_done;
    logic [CodeW-1:0] code_point;
  } res_t;

  typedef struct packed {
    logic       start_fresh;
    kind_e      kind;
    logic [6:0] bits;
  } cls_t;

endpackage

// File: sv/usv_front.sv
module usv_front (
  input  usv_pkg::in_t  in_i,
  output usv_pkg::cls_t cls_o
);
  import usv_pkg::*;

  kind_e kind;

  always_comb begin
    unique case (in_i.data_byte) inside
      [8'h00 : AsciiMax]:  kind = K_ASCII;
      [ContMin : ContMax]: kind = K_CONT;
      [Lead2Min : Lead2Max]: kind = K_LEAD2;
      [Lead3Min : Lead3Max]: kind = K_LEAD3;
      [Lead4Min : Lead4Max]: kind = K_LEAD4;
      default:             kind = K_BAD;
    endcase
  end

  assign cls_o.start_fresh = in_i.start_fresh;
  assign cls_o.kind        = kind;
  assign cls_o.bits        = in_i.data_byte[6:0];

endmodule

// File: sv/usv_cls_q.sv
module usv_cls_q (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  usv_pkg::cls_t wr_data_i,
  output logic          full_o,
  input  logic          rd_i,
  output usv_pkg::cls_t rd_data_o,
  output logic          empty_o
);
  import usv_pkg::*;

  cls_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == QCntW'(QDepth));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_i && !wr_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// File: sv/usv_res_q.sv
module usv_res_q (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  usv_pkg::res_t wr_data_i,
  output logic          full_o,
  input  logic          rd_i,
  output usv_pkg::res_t rd_data_o,
  output logic          empty_o
);
  import usv_pkg::*;

  res_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == QCntW'(QDepth));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_i && !wr_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// File: sv/usv_back.sv
`include "utf8_script_filter_validator_core_defines.svh"

module usv_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cls_valid_i,
  input  usv_pkg::cls_t cls_i,
  output logic          cls_take_o,
  input  logic          res_full_i,
  output logic          res_wr_o,
  output usv_pkg::res_t res_o
);
  import usv_pkg::*;

  // Blacklisted scripts: Turkish Latin letters, Cyrillic, kana and CJK ranges.
  function automatic logic allowed_code(input logic [CodeW-1:0] c);
    logic deny;
    deny = (c == 21'h000C7) || (c == 21'h000D6) || (c == 21'h000DC) ||
           (c == 21'h000E7) || (c == 21'h000F6) || (c == 21'h000FC) ||
           (c >= 21'h0011E && c <= 21'h0011F) ||
           (c >= 21'h00130 && c <= 21'h00131) ||
           (c >= 21'h0015E && c <= 21'h0015F) ||
           (c >= 21'h00400 && c <= 21'h0052F) ||
           (c >= 21'h01C80 && c <= 21'h01C8F) ||
           (c >= 21'h02DE0 && c <= 21'h02DFF) ||
           (c >= 21'h03040 && c <= 21'h030FF) ||
           (c >= 21'h031F0 && c <= 21'h031FF) ||
           (c >= 21'h03400 && c <= 21'h04DBF) ||
           (c >= 21'h0A640 && c <= 21'h0A69F) ||
           (c >= 21'h0F900 && c <= 21'h0FAFF) ||
           (c >= 21'h0FE2E && c <= 21'h0FE2F) ||
           (c >= 21'h0FF65 && c <= 21'h0FF9F) ||
           (c >= 21'h04E00 && c <= 21'h09FFF) ||
           (c >= 21'h1AFF0 && c <= 21'h1AFFF) ||
           (c >= 21'h1B000 && c <= 21'h1B12F) ||
           (c >= 21'h20000 && c <= 21'h2A6DF) ||
           (c >= 21'h2A700 && c <= 21'h2EE5F) ||
           (c >= 21'h2F800 && c <= 21'h2FA1F) ||
           (c >= 21'h30000 && c <= 21'h323AF);
    return !deny;
  endfunction

  logic [1:0]      pend_q, pend_d;
  logic [1:0]      len_q, len_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic            rej_q, rej_d;

  logic [1:0]       pend0, len0;
  logic [AccW-1:0]  acc0;
  logic             rej0;
  logic [1:0]       pend_dec;
  logic [CodeW-1:0] v;
  logic [CodeW-1:0] ascii_cp;
  logic [CodeW-1:0] minimum;
  logic             bad_value;
  logic             done;
  logic [CodeW-1:0] cp;
  logic             do_reject;
  logic             advance;

  assign advance    = cls_valid_i && !res_full_i;
  assign cls_take_o = advance;
  assign res_wr_o   = advance;

  // A fresh start behaves as if the state had just been cleared.
  assign pend0 = cls_i.start_fresh ? '0 : pend_q;
  assign len0  = cls_i.start_fresh ? '0 : len_q;
  assign acc0  = cls_i.start_fresh ? '0 : acc_q;
  assign rej0  = cls_i.start_fresh ? 1'b0 : rej_q;

  assign pend_dec = pend0 - 1'b1;
  assign v        = {acc0, cls_i.bits[5:0]};
  assign ascii_cp = {{(CodeW - 7){1'b0}}, cls_i.bits};

  always_comb begin
    unique case (len0)
      2'd1:    minimum = 21'h00080;
      2'd2:    minimum = 21'h00800;
      default: minimum = 21'h10000;
    endcase
  end

  assign bad_value = (v < minimum) || (v > 21'h10FFFF) ||
                     (v >= 21'h0D800 && v <= 21'h0DFFF) || !allowed_code(v);

  always_comb begin
    pend_d    = pend0;
    len_d     = len0;
    acc_d     = acc0;
    rej_d     = rej0;
    done      = 1'b0;
    cp        = '0;
    do_reject = 1'b0;
    if (!rej0) begin
      if (pend0 == '0) begin
        unique case (cls_i.kind)
          K_ASCII: begin
            if (allowed_code(ascii_cp)) begin
              done = 1'b1;
              cp   = ascii_cp;
            end else begin
              do_reject = 1'b1;
            end
          end
          K_LEAD2: begin
            pend_d = 2'd1;
            len_d  = 2'd1;
            acc_d  = {{(AccW - 5){1'b0}}, cls_i.bits[4:0]};
          end
          K_LEAD3: begin
            pend_d = 2'd2;
            len_d  = 2'd2;
            acc_d  = {{(AccW - 4){1'b0}}, cls_i.bits[3:0]};
          end
          K_LEAD4: begin
            pend_d = 2'd3;
            len_d  = 2'd3;
            acc_d  = {{(AccW - 3){1'b0}}, cls_i.bits[2:0]};
          end
          default: do_reject = 1'b1;
        endcase
      end else if (cls_i.kind != K_CONT) begin
        do_reject = 1'b1;
      end else begin
        pend_d = pend_dec;
        if (pend_dec != '0) begin
          acc_d = v[AccW-1:0];
        end else if (bad_value) begin
          do_reject = 1'b1;
        end else begin
          done  = 1'b1;
          cp    = v;
          len_d = '0;
          acc_d = '0;
        end
      end
    end
    if (do_reject) begin
      pend_d = '0;
      len_d  = '0;
      acc_d  = '0;
      rej_d  = 1'b1;
    end
  end

  always_comb begin
    res_o.code_done  = done;
    res_o.code_point = cp;
    if (rej_d) begin
      res_o.status = ST_REJECTED;
    end else if (pend_d != '0) begin
      res_o.status = ST_INSIDE;
    end else begin
      res_o.status = ST_BOUNDARY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      len_q  <= '0;
      acc_q  <= '0;
      rej_q  <= 1'b0;
    end else if (advance) begin
      pend_q <= pend_d;
      len_q  <= len_d;
      acc_q  <= acc_d;
      rej_q  <= rej_d;
    end
  end

  `USV_ASSERT(a_pend_not_rej, (pend_q != '0) |-> !rej_q)
  `USV_ASSERT(a_rej_cleared, rej_q |-> (acc_q == '0) && (len_q == '0))
  `USV_ASSERT(a_pend_le_len, pend_q <= len_q)
  `USV_ASSERT(a_done_boundary, (res_wr_o && res_o.code_done) |-> (res_o.status == ST_BOUNDARY))
  `USV_ASSERT_NR(a_reset_clear, !rst_ni |=> !rej_q && (pend_q == '0))

endmodule

// File: sv/utf8_script_filter_validator_core.sv
// A byte accepted on push enters the classified-byte queue; the decoder then takes it
// from there, decodes it combinationally and writes the result to the result queue.
// Throughput: one byte per cycle while the result queue is not full.
// Reset (rst_ni low, asynchronous) empties both queues and returns the decoder
// to the accepting state with no pending sequence.
module utf8_script_filter_validator_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  input  usv_pkg::in_t  in_i,
  output logic          full,
  input  logic          pop,
  output usv_pkg::res_t res_o,
  output logic          empty
);
  import usv_pkg::*;

  cls_t cls_in;
  cls_t cls_out;
  logic cls_wr;
  logic cls_empty;
  logic cls_take;
  logic res_full;
  logic res_wr;
  res_t res_data;

  assign cls_wr = push && !full;

  usv_front u_front (
    .in_i  (in_i),
    .cls_o (cls_in)
  );

  usv_cls_q u_cls_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cls_wr),
    .wr_data_i (cls_in),
    .full_o    (full),
    .rd_i      (cls_take),
    .rd_data_o (cls_out),
    .empty_o   (cls_empty)
  );

  usv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_valid_i (!cls_empty),
    .cls_i       (cls_out),
    .cls_take_o  (cls_take),
    .res_full_i  (res_full),
    .res_wr_o    (res_wr),
    .res_o       (res_data)
  );

  usv_res_q u_res_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (res_wr),
    .wr_data_i (res_data),
    .full_o    (res_full),
    .rd_i      (pop && !empty),
    .rd_data_o (res_o),
    .empty_o   (empty)
  );

endmodule

// File: dv/utf8_decode_checker.sv
module utf8_decode_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  usv_pkg::in_t  in_i,
  input  logic          full_i,
  input  logic          pop_i,
  input  usv_pkg::res_t res_i,
  input  logic          empty_i,
  output int unsigned   fail_count_o,
  output int unsigned   outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import usv_pkg::*;

  localparam int unsigned ReportMax = 10;

  // Shadow of the decoder state.
  logic [1:0]  pend_cnt;
  logic [1:0]  seq_len;
  logic [20:0] code_acc;
  logic        rejected;

  res_t        decoded_q[$];
  res_t        want;
  int unsigned mismatch_count = 0;
  int unsigned waiting_count = 0;

  assign fail_count_o  = mismatch_count;
  assign outstanding_o = waiting_count;

  function automatic bit in_span(logic [20:0] c, logic [20:0] lo, logic [20:0] hi);
    return (c >= lo) && (c <= hi);
  endfunction

  function automatic bit permitted(logic [20:0] c);
    if (c == 21'h00C7 || c == 21'h00D6 || c == 21'h00DC || c == 21'h00E7 ||
        c == 21'h00F6 || c == 21'h00FC || in_span(c, 21'h011E, 21'h011F) ||
        in_span(c, 21'h0130, 21'h0131) || in_span(c, 21'h015E, 21'h015F))
      return 1'b0;
    return !(in_span(c, 21'h0400, 21'h052F) || in_span(c, 21'h1C80, 21'h1C8F) ||
             in_span(c, 21'h2DE0, 21'h2DFF) || in_span(c, 21'h3040, 21'h30FF) ||
             in_span(c, 21'h31F0, 21'h31FF) || in_span(c, 21'h3400, 21'h4DBF) ||
             in_span(c, 21'hA640, 21'hA69F) || in_span(c, 21'hF900, 21'hFAFF) ||
             in_span(c, 21'hFE2E, 21'hFE2F) || in_span(c, 21'hFF65, 21'hFF9F) ||
             in_span(c, 21'h4E00, 21'h9FFF) || in_span(c, 21'h1AFF0, 21'h1AFFF) ||
             in_span(c, 21'h1B000, 21'h1B12F) || in_span(c, 21'h20000, 21'h2A6DF) ||
             in_span(c, 21'h2A700, 21'h2EE5F) || in_span(c, 21'h2F800, 21'h2FA1F) ||
             in_span(c, 21'h30000, 21'h323AF));
  endfunction

  function automatic void clear_state();
    pend_cnt = '0;
    seq_len  = '0;
    code_acc = '0;
    rejected = 1'b0;
  endfunction

  function automatic void enter_reject();
    clear_state();
    rejected = 1'b1;
  endfunction

  function automatic res_t decode_byte(in_t beat);
    logic [7:0]  b;
    logic [20:0] v;
    logic [20:0] lowest;
    res_t        r;
    b = beat.data_byte;
    r = '0;
    if (beat.start_fresh) clear_state();
    if (!rejected) begin
      if (pend_cnt == 2'd0) begin
        if (b <= AsciiMax) begin
          if (permitted({13'd0, b})) begin
            r.code_done  = 1'b1;
            r.code_point = {13'd0, b};
          end else begin
            enter_reject();
          end
        end else if (b >= Lead2Min && b <= Lead2Max) begin
          pend_cnt = 2'd1;
          seq_len  = 2'd1;
          code_acc = {16'd0, b[4:0]};
        end else if (b >= Lead3Min && b <= Lead3Max) begin
          pend_cnt = 2'd2;
          seq_len  = 2'd2;
          code_acc = {17'd0, b[3:0]};
        end else if (b >= Lead4Min && b <= Lead4Max) begin
          pend_cnt = 2'd3;
          seq_len  = 2'd3;
          code_acc = {18'd0, b[2:0]};
        end else begin
          enter_reject();
        end
      end else if (b[7:6] != 2'b10) begin
        enter_reject();
      end else begin
        v = {code_acc[14:0], b[5:0]};
        pend_cnt = pend_cnt - 2'd1;
        if (pend_cnt != 2'd0) begin
          code_acc = v;
        end else begin
          case (seq_len)
            2'd1:    lowest = 21'h80;
            2'd2:    lowest = 21'h800;
            default: lowest = 21'h10000;
          endcase
          // Overlong, too large and surrogate forms are only known at the last byte.
          if (v < lowest || v > 21'h10FFFF || in_span(v, 21'hD800, 21'hDFFF) ||
              !permitted(v)) begin
            enter_reject();
          end else begin
            r.code_done  = 1'b1;
            r.code_point = v;
            seq_len      = '0;
            code_acc     = '0;
          end
        end
      end
    end
    if (rejected)              r.status = ST_REJECTED;
    else if (pend_cnt != 2'd0) r.status = ST_INSIDE;
    else                       r.status = ST_BOUNDARY;
    return r;
  endfunction

  task automatic note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= ReportMax) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_state();
      decoded_q.delete();
    end else begin
      if (push_i && !full_i) decoded_q.push_back(decode_byte(in_i));
      if (pop_i && !empty_i) begin
        if (decoded_q.size() == 0) begin
          note_failure($sformatf("result beat with nothing expected: status %0d done %0b cp %06h",
                                 res_i.status, res_i.code_done, res_i.code_point));
        end else begin
          want = decoded_q.pop_front();
          if (want.status !== res_i.status || want.code_done !== res_i.code_done ||
              want.code_point !== res_i.code_point)
            note_failure($sformatf(
              "mismatch: expected status %0d done %0b cp %06h, got status %0d done %0b cp %06h",
              want.status, want.code_done, want.code_point,
              res_i.status, res_i.code_done, res_i.code_point));
        end
      end
    end
    waiting_count = decoded_q.size();
  end

endmodule

// File: dv/utf8_script_filter_validator_core_tb.sv
module utf8_script_filter_validator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import usv_pkg::*;

  localparam int unsigned StreamLen  = 1125;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldStart  = 200;
  localparam int unsigned HoldLen    = 400;

  typedef enum int {
    RX_EAGER,
    RX_COIN,
    RX_SPARSE
  } rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push;
  in_t         in_i;
  logic        full;
  logic        pop;
  res_t        res_o;
  logic        empty;
  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned cycle_count = 0;

  in_t stream_q[$];
  bit  need_fresh;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  utf8_script_filter_validator_core uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push  (push),
    .in_i  (in_i),
    .full  (full),
    .pop   (pop),
    .res_o (res_o),
    .empty (empty)
  );

  utf8_decode_checker u_decode_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .in_i         (in_i),
    .full_i       (full),
    .pop_i        (pop),
    .res_i        (res_o),
    .empty_i      (empty),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding)
  );

  task automatic put(input logic [7:0] b, input logic fresh);
    in_t beat;
    beat.data_byte   = b;
    beat.start_fresh = fresh;
    stream_q.push_back(beat);
  endtask

  // Encodes cp in len bytes without checking the length, so short values give
  // overlong forms, and only the first keep bytes are queued.
  task automatic add_char(input logic [20:0] cp, input int len, input int keep);
    logic [3:0][7:0] enc;
    logic            fresh;
    fresh      = need_fresh || ($urandom_range(0, 9) == 0);
    need_fresh = 1'b0;
    case (len)
      1: enc[0] = {1'b0, cp[6:0]};
      2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) put(enc[i], (i == 0) ? fresh : 1'b0);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: stalls follow a randomly redrawn mode, plus one long hold-off
  // that lets the block fill up and push back on the sender.
  initial begin : receiver
    int unsigned rx_cycle;
    rx_mode_e    mode;
    rx_cycle = 0;
    mode     = RX_EAGER;
    pop      = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (rx_cycle % 64 == 0) mode = rx_mode_e'($urandom_range(0, 2));
      if (rx_cycle >= HoldStart && rx_cycle < HoldStart + HoldLen) begin
        pop <= 1'b0;
      end else begin
        case (mode)
          RX_EAGER: pop <= 1'b1;
          RX_COIN:  pop <= 1'($urandom_range(0, 1));
          default:  pop <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int          pick;
    int          len;
    int          keep;
    int          burst;
    int          gap;
    logic [20:0] cp;
    rst_ni = 1'b0;
    push   = 1'b0;
    in_i   = '0;

    // Directed: range extremes, then ways to get rejected and to recover.
    need_fresh = 1'b1;
    add_char(21'h00, 1, 1);
    add_char(21'h7F, 1, 1);
    add_char(21'h80, 2, 2);
    add_char(21'hFFFF, 3, 3);
    add_char(21'h10FFFF, 4, 4);
    add_char(21'h0410, 2, 2);      // Cyrillic, blacklisted
    put(8'h41, 1'b0);              // sticky rejection
    need_fresh = 1'b1;
    add_char(21'hD800, 3, 3);      // surrogate
    need_fresh = 1'b1;
    add_char(21'h00, 3, 3);        // overlong three-byte form
    need_fresh = 1'b1;
    add_char(21'h80, 2, 1);
    put(8'h41, 1'b0);              // ASCII byte where a continuation belongs
    put(8'hFF, 1'b1);              // bad lead byte
    need_fresh = 1'b1;
    add_char(21'h110000, 4, 4);    // above the code space

    while (stream_q.size() < StreamLen) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        add_char(21'($urandom_range(0, 21'h7F)), 1, 1);
      end else if (pick < 45) begin
        add_char(21'($urandom_range(21'h80, 21'h7FF)), 2, 2);
      end else if (pick < 60) begin
        add_char(21'($urandom_range(21'h800, 21'hFFFF)), 3, 3);
      end else if (pick < 70) begin
        add_char(21'($urandom_range(21'h10000, 21'h10FFFF)), 4, 4);
      end else if (pick < 78) begin
        // Edges of the blacklisted ranges, inside and just outside.
        case ($urandom_range(0, 19))
          0:  cp = 21'h011E;
          1:  cp = 21'h011F;
          2:  cp = 21'h0130;
          3:  cp = 21'h015F;
          4:  cp = 21'h03FF;
          5:  cp = 21'h0400;
          6:  cp = 21'h052F;
          7:  cp = 21'h0530;
          8:  cp = 21'h303F;
          9:  cp = 21'h3040;
          10: cp = 21'h4E00;
          11: cp = 21'h9FFF;
          12: cp = 21'hA000;
          13: cp = 21'h323AF;
          14: cp = 21'h323B0;
          15: cp = 21'h20000;
          16: cp = 21'h00C7;
          17: cp = 21'h00FC;
          18: cp = 21'hFE2E;
          default: cp = 21'h1AFF0;
        endcase
        if (cp < 21'h80)         len = 1;
        else if (cp < 21'h800)   len = 2;
        else if (cp < 21'h10000) len = 3;
        else                     len = 4;
        add_char(cp, len, len);
        need_fresh = ($urandom_range(0, 3) != 0);
      end else if (pick < 84) begin
        len = $urandom_range(2, 4);
        case (len)
          2:       cp = 21'($urandom_range(0, 21'h7F));
          3:       cp = 21'($urandom_range(0, 21'h7FF));
          default: cp = 21'($urandom_range(0, 21'hFFFF));
        endcase
        add_char(cp, len, len);
        need_fresh = ($urandom_range(0, 3) != 0);
      end else if (pick < 88) begin
        add_char(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4, 4);
        need_fresh = ($urandom_range(0, 3) != 0);
      end else if (pick < 94) begin
        len  = $urandom_range(2, 4);
        keep = $urandom_range(1, len - 1);
        add_char(21'($urandom_range(21'h80, 21'h10FFFF)), len, keep);
        need_fresh = 1'($urandom_range(0, 1));
      end else begin
        repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        need_fresh = 1'b1;
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    while (stream_q.size() > 0) begin
      burst = $urandom_range(1, 32);
      while (burst > 0 && stream_q.size() > 0) begin
        push <= 1'b1;
        in_i <= stream_q.pop_front();
        @(posedge clk_i);
        while (full) @(posedge clk_i);
        @(negedge clk_i);
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    push <= 1'b0;

    do @(negedge clk_i); while (outstanding != 0);
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
